>>> rtl/ssb_pkg.sv
`default_nettype none
package ssb_pkg;

    localparam int NUM_STEPS = 16;
    localparam int IDX_W     = $clog2(NUM_STEPS);
    localparam int CNT_W     = $clog2(NUM_STEPS + 1);
    localparam int CMD_W     = 3;
    localparam int QLEN_W    = 5;

    // Command codes carried in the input item.
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REQUEUE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REWIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    // Per-step state codes.
    localparam logic [1:0] ST_QUEUED   = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_ABORTED  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_RANGE     = 2'd1;
    localparam logic [1:0] STS_EXHAUSTED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan_step;
        logic load_out;
    } t_ssb_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_ssb_sts;

    // Number of steps in use: zero reads as one, anything above the table size is clipped.
    function automatic logic [CNT_W-1:0] steps_in_use(input logic [QLEN_W-1:0] q);
        logic [CNT_W-1:0] len;
        begin
            if (q == '0) begin
                len = CNT_W'(1);
            end else if (q > QLEN_W'(NUM_STEPS)) begin
                len = CNT_W'(NUM_STEPS);
            end else begin
                len = CNT_W'(q);
            end
            return len;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/ssb_ctrl.sv
`default_nettype none
module ssb_ctrl
    import ssb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ssb_sts i_sts,
    output t_ssb_ctl      o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_item = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("controller state not one-hot");
    a_exec_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_item |=> o_ctl.exec)
        else $error("accepted item not executed next cycle");
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> i_sts.out_free)
        else $error("result load issued while the output register is occupied");

endmodule
`default_nettype wire

>>> rtl/ssb_dp.sv
`default_nettype none
module ssb_dp
    import ssb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ssb_ctl          i_ctl,
    output t_ssb_sts               o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [QLEN_W-1:0] i_cfg_wdata,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [IDX_W-1:0]  i_step_index,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [IDX_W-1:0]       o_dispatched_index,
    output logic                   o_dispatch_valid,
    output logic [1:0]             o_step_state,
    output logic [CNT_W-1:0]       o_pointer_now,
    output logic [CNT_W-1:0]       o_aborted_count,
    output logic [1:0]             o_status
);

    logic [QLEN_W-1:0] r_queue_length;
    logic [CNT_W-1:0]  len;

    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic [1:0]        r_states [NUM_STEPS];
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  n_ptr;

    logic [IDX_W-1:0]  r_didx;
    logic              r_dval;
    logic [1:0]        r_qstate;
    logic [1:0]        r_status;
    logic [IDX_W-1:0]  n_didx;
    logic              n_dval;
    logic [1:0]        n_qstate;
    logic [1:0]        n_status;

    logic [CNT_W-1:0]  r_scan;
    logic [CNT_W-1:0]  r_acount;
    logic              r_found;
    logic [IDX_W-1:0]  r_first;

    logic [IDX_W-1:0]  rd_addr;
    logic [1:0]        rd_data;
    logic              idx_ok;
    logic              ptr_ok;

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_out_didx;
    logic              r_out_dval;
    logic [1:0]        r_out_qstate;
    logic [CNT_W-1:0]  r_out_ptr;
    logic [CNT_W-1:0]  r_out_acount;
    logic [1:0]        r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_length <= QLEN_W'(1);
        end else if (i_cfg_we) begin
            r_queue_length <= i_cfg_wdata;
        end
    end

    assign len = steps_in_use(r_queue_length);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_cmd <= i_cmd;
            r_idx <= i_step_index;
        end
    end

    // One read port into the table, shared by the query and the scan.
    assign rd_addr = i_ctl.exec ? r_idx : r_scan[IDX_W-1:0];
    assign rd_data = r_states[rd_addr];
    assign idx_ok  = ({1'b0, r_idx} < len);
    assign ptr_ok  = (r_ptr < len);

    always_comb begin
        n_ptr = r_ptr;
        if (i_ctl.exec) begin
            if (r_cmd == CMD_DISPATCH && ptr_ok) begin
                n_ptr = r_ptr + CNT_W'(1);
            end else if (r_cmd == CMD_REQUEUE) begin
                n_ptr = '0;
            end
        end else if (i_ctl.load_out && r_cmd == CMD_REWIND && r_found) begin
            n_ptr = CNT_W'(r_first);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STEPS; i++) begin
                r_states[i] <= ST_QUEUED;
            end
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_ctl.exec) begin
                unique case (r_cmd)
                    CMD_DISPATCH: begin
                        if (ptr_ok) begin
                            r_states[r_ptr[IDX_W-1:0]] <= ST_ACTIVE;
                        end
                    end
                    CMD_COMPLETE: begin
                        if (idx_ok) begin
                            r_states[r_idx] <= ST_COMPLETE;
                        end
                    end
                    CMD_ABORT: begin
                        if (idx_ok) begin
                            r_states[r_idx] <= ST_ABORTED;
                        end
                    end
                    CMD_REQUEUE: begin
                        for (int i = 0; i < NUM_STEPS; i++) begin
                            r_states[i] <= ST_QUEUED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Per-item result fields, settled in the execute cycle.
    always_comb begin
        n_didx   = '0;
        n_dval   = 1'b0;
        n_qstate = ST_QUEUED;
        n_status = STS_OK;
        unique case (r_cmd)
            CMD_DISPATCH: begin
                if (ptr_ok) begin
                    n_didx = r_ptr[IDX_W-1:0];
                    n_dval = 1'b1;
                end else begin
                    n_status = STS_EXHAUSTED;
                end
            end
            CMD_COMPLETE, CMD_ABORT: begin
                if (!idx_ok) begin
                    n_status = STS_RANGE;
                end
            end
            CMD_QUERY: begin
                if (idx_ok) begin
                    n_qstate = rd_data;
                end else begin
                    n_status = STS_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_didx   <= n_didx;
            r_dval   <= n_dval;
            r_qstate <= n_qstate;
            r_status <= n_status;
        end
    end

    // Scan over the steps in use: count aborted steps, find the first rewind target.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_scan   <= '0;
            r_acount <= '0;
            r_found  <= 1'b0;
            r_first  <= '0;
        end else if (i_ctl.scan_step) begin
            r_scan <= r_scan + CNT_W'(1);
            if (rd_data == ST_ABORTED) begin
                r_acount <= r_acount + CNT_W'(1);
            end
            if (!r_found && (rd_data == ST_QUEUED || rd_data == ST_ABORTED)) begin
                r_found <= 1'b1;
                r_first <= r_scan[IDX_W-1:0];
            end
        end
    end

    assign o_sts.scan_last = ((r_scan + CNT_W'(1)) == len);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_didx   <= r_didx;
            r_out_dval   <= r_dval;
            r_out_qstate <= r_qstate;
            r_out_ptr    <= n_ptr;
            r_out_acount <= r_acount;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_dispatched_index = r_out_didx;
    assign o_dispatch_valid   = r_out_dval;
    assign o_step_state       = r_out_qstate;
    assign o_pointer_now      = r_out_ptr;
    assign o_aborted_count    = r_out_acount;
    assign o_status           = r_out_status;

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= CNT_W'(NUM_STEPS))
        else $error("dispatch pointer beyond table");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.scan_step |-> (r_scan < len))
        else $error("scan ran past the steps in use");
    a_dval_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out_dval) |-> (r_out_status == STS_OK))
        else $error("dispatched step reported with error status");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |-> (!r_ovalid || i_out_ready))
        else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

>>> rtl/step_dispatch_scoreboard.sv
// Step dispatch scoreboard.
// Keeps a state (queued, active, complete, aborted) for each of 16 steps and a
// dispatch pointer. Commands arrive as items on the s_axis channel; every
// command returns exactly one result item on the m_axis channel, carrying the
// dispatched index, the queried state, the pointer after the command, the
// number of aborted steps in use and a status code.
// The number of steps in use is set through i_cfg_we / i_cfg_wdata, which
// should only be written while no command is in flight.
// A command item is accepted only while the block is idle. Its result item is
// offered after the command has been executed, after a single table read port
// has swept the L steps in use (1 to 16) to count aborted ones and find the
// rewind target, and after the result has been loaded into the output register.
// The block is ready again in the cycle after that load, so it takes a new item
// only once the result of the last one is in the output register.
// The output register decouples the two sides: a new item is accepted while
// the previous result still waits; if the receiver stalls, the next result
// is held in the datapath until the output register frees.
// Reset (synchronous, active low) marks every step queued, clears the pointer,
// sets the length to one and empties the output register.
`default_nettype none
module step_dispatch_scoreboard
    import ssb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,   // queue_length
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [2:0] cmd, [6:3] step_index, [7] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [3:0] dispatched_index, [5:4] step_state,
                                            // [10:6] pointer_now, [15:11] aborted_count
    output logic [2:0]       m_axis_tuser   // [0] dispatch_valid, [2:1] status
);

    t_ssb_ctl         ctl;
    t_ssb_sts         sts;
    logic [IDX_W-1:0] dispatched_index;
    logic             dispatch_valid;
    logic [1:0]       step_state;
    logic [CNT_W-1:0] pointer_now;
    logic [CNT_W-1:0] aborted_count;
    logic [1:0]       status;

    // The controller sequences capture, execute, scan and result load.
    ssb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // The datapath holds the step table, the pointer and the output register.
    ssb_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (s_axis_tdata[2:0]),
        .i_step_index       (s_axis_tdata[6:3]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_dispatched_index (dispatched_index),
        .o_dispatch_valid   (dispatch_valid),
        .o_step_state       (step_state),
        .o_pointer_now      (pointer_now),
        .o_aborted_count    (aborted_count),
        .o_status           (status)
    );

    // Fields packed from the lowest bit up; the spare bit of the input byte is ignored.
    assign m_axis_tdata = {aborted_count, pointer_now, step_state, dispatched_index};
    assign m_axis_tuser = {status, dispatch_valid};

endmodule
`default_nettype wire

>>> sim/step_dispatch_scoreboard_tb.sv
`timescale 1ns / 1ps
module step_dispatch_scoreboard_tb;
    import ssb_pkg::*;

    // Command codes that the block does not use. They must change nothing and answer ok.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Number of items in each random phase; eight phases give roughly 700 items.
    localparam int PHASE_ITEMS = 85;
    // Cycles after the last result.
    localparam int TAIL_CYCLES = 2 * (NUM_STEPS + 3);
    // Generous cycle budget. The slowest correct run needs roughly 750 items of work
    // plus sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 400000;

    // One result item, split into its fields.
    typedef struct {
        logic [IDX_W-1:0] disp_index;
        logic             disp_valid;
        logic [1:0]       queried_state;
        logic [4:0]       pointer_after;
        logic [4:0]       aborted_total;
        logic [1:0]       status;
    } t_step_result;

    // The scoreboard keeps its own copy of the step table, the dispatch pointer and the
    // length register. Every accepted command is run against that copy, and the answer
    // is queued until the block returns its result.
    class t_dispatch_board;
        logic [1:0]   step_tbl [NUM_STEPS];
        logic [4:0]   ptr;
        logic [4:0]   qlen;
        t_step_result awaited [$];
        int           errors;

        function new();
            foreach (step_tbl[i]) step_tbl[i] = ST_QUEUED;
            ptr    = '0;
            qlen   = 5'd1;
            errors = 0;
        endfunction

        function void set_length(logic [4:0] value);
            qlen = value;
        endfunction

        // A length of zero counts as one, and anything above the table size is clipped.
        function int length_in_use();
            if (qlen == 0) return 1;
            if (qlen > NUM_STEPS) return NUM_STEPS;
            return qlen;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
            t_step_result r;
            int           len;
            bit           found;
            len             = length_in_use();
            found           = 1'b0;
            r.disp_index    = '0;
            r.disp_valid    = 1'b0;
            r.queried_state = ST_QUEUED;
            r.status        = STS_OK;
            case (cmd)
                CMD_DISPATCH: begin
                    if (ptr < len) begin
                        step_tbl[ptr[IDX_W-1:0]] = ST_ACTIVE;
                        r.disp_index = ptr[IDX_W-1:0];
                        r.disp_valid = 1'b1;
                        ptr          = ptr + 5'd1;
                    end else begin
                        r.status = STS_EXHAUSTED;
                    end
                end
                CMD_COMPLETE, CMD_ABORT: begin
                    if (idx < len) begin
                        step_tbl[idx] = (cmd == CMD_COMPLETE) ? ST_COMPLETE : ST_ABORTED;
                    end else begin
                        r.status = STS_RANGE;
                    end
                end
                CMD_REQUEUE: begin
                    // The whole table is cleared, steps beyond the length in use too.
                    foreach (step_tbl[i]) step_tbl[i] = ST_QUEUED;
                    ptr = '0;
                end
                CMD_REWIND: begin
                    // The first queued or aborted step wins; with none the pointer stays.
                    for (int i = 0; i < len; i++) begin
                        if (!found && (step_tbl[i] == ST_QUEUED || step_tbl[i] == ST_ABORTED)) begin
                            ptr   = 5'(i);
                            found = 1'b1;
                        end
                    end
                end
                CMD_QUERY: begin
                    if (idx < len) begin
                        r.queried_state = step_tbl[idx];
                    end else begin
                        r.status = STS_RANGE;
                    end
                end
                default: begin
                end
            endcase
            r.pointer_after = ptr;
            r.aborted_total = '0;
            for (int i = 0; i < len; i++) begin
                if (step_tbl[i] == ST_ABORTED) r.aborted_total = r.aborted_total + 5'd1;
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] tdata, logic [2:0] tuser);
            t_step_result e;
            if (awaited.size() == 0) begin
                $error("result item arrived with no command outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            compare_field("dispatched_index", e.disp_index,    tdata[3:0]);
            compare_field("step_state",       e.queried_state, tdata[5:4]);
            compare_field("pointer_now",      e.pointer_after, tdata[10:6]);
            compare_field("aborted_count",    e.aborted_total, tdata[15:11]);
            compare_field("dispatch_valid",   e.disp_valid,    tuser[0]);
            compare_field("status",           e.status,        tuser[2:1]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [2:0] cmd, [6:3] step_index, [7] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [3:0] dispatched_index, [5:4] step_state,
                                 // [10:6] pointer_now, [15:11] aborted_count
    logic [2:0]  m_axis_tuser;   // [0] dispatch_valid, [2:1] status

    t_dispatch_board board;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              cycles;

    step_dispatch_scoreboard u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver decides at each falling edge whether it will take a result at the
    // next rising edge. A stall percentage of zero keeps it ready throughout.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Results are taken at the rising edge, so the values seen are those from before it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** step_dispatch_scoreboard: FAILED **");
            $finish;
        end
    end

    // Offers one command item and returns at the rising edge where it is accepted.
    // The valid line is left high afterwards, so that a following item can be presented
    // at the next falling edge without a gap; an idle cycle lowers it instead.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, idx, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_command(cmd, idx);
    endtask

    // Withdraws the sender and waits until every outstanding result has come back.
    // Every command gives exactly one result, so the block is idle once they are all in;
    // an extra wait is still allowed before anything is reconfigured.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_length(logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_length(value);
    endtask

    // Random commands, shaped like a real schedule: mostly dispatches followed by
    // completions and aborts of steps already handed out, with queries, rewinds and the
    // odd requeue mixed in. A small share is noise: spare codes and indices anywhere in
    // the field, including those beyond the length in use.
    task automatic random_command();
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        int               roll;
        int               len;
        int               span;
        len  = board.length_in_use();
        span = (board.ptr > 0 && board.ptr <= len) ? int'(board.ptr) : len;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) begin
            idx = IDX_W'($urandom_range(0, span - 1));
        end else begin
            idx = IDX_W'($urandom_range(0, NUM_STEPS - 1));
        end
        if (roll < 35)      cmd = CMD_DISPATCH;
        else if (roll < 50) cmd = CMD_COMPLETE;
        else if (roll < 62) cmd = CMD_ABORT;
        else if (roll < 76) cmd = CMD_QUERY;
        else if (roll < 87) cmd = CMD_REWIND;
        else if (roll < 92) cmd = CMD_REQUEUE;
        else if (roll < 96) cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        else                cmd = CMD_W'($urandom_range(0, 7));
        send_command(cmd, idx);
    endtask

    initial begin
        logic [4:0] lengths [8];
        board              = new();
        cycles             = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        m_axis_tready      = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset length of one: dispatch of the single step, then an
        // exhausted queue, indices out of range, an abort picked up again by rewind, the
        // spare codes and a requeue.
        send_command(CMD_QUERY,    4'd0);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_QUERY,    4'd15);
        send_command(CMD_COMPLETE, 4'd15);
        send_command(CMD_ABORT,    4'd0);
        send_command(CMD_REWIND,   4'd0);
        send_command(CMD_QUERY,    4'd0);
        send_command(CMD_SPARE_A,  4'd0);
        send_command(CMD_SPARE_B,  4'd15);
        send_command(CMD_REQUEUE,  4'd0);

        // Full table: rewind onto an aborted step, then onto the first queued one, and the
        // highest index completed and read back before and after a requeue.
        drain_results();
        write_length(5'd16);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_COMPLETE, 4'd0);
        send_command(CMD_ABORT,    4'd2);
        send_command(CMD_ABORT,    4'd15);
        send_command(CMD_QUERY,    4'd2);
        send_command(CMD_REWIND,   4'd0);
        send_command(CMD_DISPATCH, 4'd0);
        send_command(CMD_REWIND,   4'd0);
        send_command(CMD_COMPLETE, 4'd15);
        send_command(CMD_QUERY,    4'd15);
        send_command(CMD_REQUEUE,  4'd0);
        send_command(CMD_QUERY,    4'd15);

        // Random phases. The length changes between phases without a requeue, so that a
        // shrunk queue keeps steps beyond its end. Zero, 17 and 31 stand in for the lengths that
        // read as one or are clipped; zero and 31 put every bit of the register through both values.
        lengths = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd17, 5'd0, 5'd12};
        lengths[6] = 5'($urandom_range(2, 15));
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            write_length(lengths[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Half way through each phase the sender holds off until every result is in.
                if (n == PHASE_ITEMS / 2) drain_results();
                random_command();
            end
        end

        drain_results();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.outstanding() != 0) begin
            $error("%0d result items never arrived", board.outstanding());
            board.errors++;
        end

        if (board.errors == 0) begin
            $display("** step_dispatch_scoreboard: PASSED **");
        end else begin
            $display("** step_dispatch_scoreboard: FAILED **");
        end
        $finish;
    end

endmodule

>>> step_dispatch_scoreboard.f
rtl/ssb_pkg.sv
rtl/ssb_ctrl.sv
rtl/ssb_dp.sv
rtl/step_dispatch_scoreboard.sv
sim/step_dispatch_scoreboard_tb.sv
